[sv/csmc_pkg.sv]
// Shared types, codes and constants for the cruise speed and mode controller.
package csmc_pkg;

    localparam int LEVEL_W = 10;
    localparam int DIST_W  = 16;
    localparam int TGT_W   = 16;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 10'd1000;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN  = 10'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_RUN  = 10'd150;
    localparam logic [LEVEL_W:0]   STEP_CMD   = 11'd50;
    localparam logic [LEVEL_W:0]   STEP_ACC   = 11'd10;
    localparam logic [LEVEL_W:0]   STEP_COAST = 11'd2;
    localparam logic [11:0]        DISP_RECIP = 12'd3277;

    localparam logic [7:0] CMD_ACCEL    = 8'h41;
    localparam logic [7:0] CMD_DECEL    = 8'h44;
    localparam logic [7:0] CMD_STOP     = 8'h53;
    localparam logic [7:0] CMD_OFF      = 8'h4F;
    localparam logic [7:0] CMD_NORMAL   = 8'h4E;
    localparam logic [7:0] CMD_ADAPTIVE = 8'h50;
    localparam logic [7:0] CMD_CLOSE    = 8'h43;
    localparam logic [7:0] CMD_MEDIUM   = 8'h4D;
    localparam logic [7:0] CMD_FAR      = 8'h46;
    localparam logic [7:0] CMD_TGT_UP   = 8'h49;
    localparam logic [7:0] CMD_TGT_DN   = 8'h4A;

    localparam logic [CFG_IDX_W-1:0] CFG_FAR_UPPER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LOWER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_UPPER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_LOWER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_UPPER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LOWER  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DANGER_GAP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_GAP     = 3'd7;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_NORMAL   = 2'd1,
        MODE_ADAPTIVE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        BAND_NONE   = 2'd0,
        BAND_CLOSE  = 2'd1,
        BAND_MEDIUM = 2'd2,
        BAND_FAR    = 2'd3
    } t_band;

    typedef enum logic [1:0] {
        LIGHT_NONE  = 2'd0,
        LIGHT_ACCEL = 2'd1,
        LIGHT_DECEL = 2'd2,
        LIGHT_STOP  = 2'd3
    } t_light;

    typedef struct packed {
        logic [CFG_W-1:0] far_upper;
        logic [CFG_W-1:0] far_lower;
        logic [CFG_W-1:0] medium_upper;
        logic [CFG_W-1:0] medium_lower;
        logic [CFG_W-1:0] close_upper;
        logic [CFG_W-1:0] close_lower;
        logic [CFG_W-1:0] danger_gap;
        logic [CFG_W-1:0] warn_gap;
    } t_cfg;

    typedef struct packed {
        t_mode              mode;
        logic [LEVEL_W-1:0] level;
        logic [TGT_W-1:0]   target;
        t_band              pending_band;
        t_band              active_band;
    } t_state;

    typedef struct packed {
        logic [LEVEL_W-1:0] duty;
        logic [5:0]         speed_display;
        logic               buzzer;
        t_mode              drive_mode;
        logic [TGT_W-1:0]   target_level;
        t_light             light_event;
    } t_result;

endpackage

[sv/cruise_speed_mode_controller_top.sv]
// Top level of the cruise speed and mode controller.
// Each accepted word is one control tick: it is registered on entry, processed
// combinationally against the mode/level/target/band state, and its result word is
// registered on exit into the result register once the output side can take it;
// one word is accepted per cycle when the output side is not stalled. Threshold
// registers are written through the plain write port and take effect on the next tick.
module cruise_speed_mode_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_cmd_byte,
    input  logic [csmc_pkg::DIST_W-1:0]    i_distance,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [csmc_pkg::LEVEL_W-1:0]   o_duty,
    output logic [5:0]                     o_speed_display,
    output logic                           o_buzzer,
    output logic [1:0]                     o_drive_mode,
    output logic [csmc_pkg::TGT_W-1:0]     o_target_level,
    output logic [1:0]                     o_light_event,
    input  logic                           i_cfg_we,
    input  logic [csmc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [csmc_pkg::CFG_W-1:0]     i_cfg_data
);
    import csmc_pkg::*;

    logic              r_in_vld;
    logic [7:0]        r_cmd;
    logic [DIST_W-1:0] r_dist;
    t_state            r_st;
    t_state            n_st;
    logic              r_out_vld;
    t_result           r_out;
    t_result           n_out;
    t_cfg              w_cfg;
    logic              w_adv;

    csmc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    csmc_step u_step (
        .i_cfg    (w_cfg),
        .i_state  (r_st),
        .i_cmd    (r_cmd),
        .i_dist   (r_dist),
        .o_state  (n_st),
        .o_result (n_out)
    );

    assign w_adv      = r_in_vld & (~r_out_vld | ~i_out_stall);
    assign o_in_stall = r_in_vld & ~w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cmd  <= i_cmd_byte;
            r_dist <= i_distance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode         <= MODE_OFF;
            r_st.level        <= LEVEL_MIN;
            r_st.target       <= TGT_W'(LEVEL_MIN);
            r_st.pending_band <= BAND_NONE;
            r_st.active_band  <= BAND_NONE;
        end else if (w_adv) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_duty          = r_out.duty;
    assign o_speed_display = r_out.speed_display;
    assign o_buzzer        = r_out.buzzer;
    assign o_drive_mode    = r_out.drive_mode;
    assign o_target_level  = r_out.target_level;
    assign o_light_event   = r_out.light_event;

endmodule

[sv/csmc_cfg.sv]
// Threshold register file with write port.
module csmc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [csmc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [csmc_pkg::CFG_W-1:0]   i_cfg_data,
    output csmc_pkg::t_cfg               o_cfg
);
    import csmc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.far_upper    <= 8'd80;
            r_cfg.far_lower    <= 8'd60;
            r_cfg.medium_upper <= 8'd50;
            r_cfg.medium_lower <= 8'd40;
            r_cfg.close_upper  <= 8'd30;
            r_cfg.close_lower  <= 8'd20;
            r_cfg.danger_gap   <= 8'd15;
            r_cfg.warn_gap     <= 8'd30;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FAR_UPPER:    r_cfg.far_upper    <= i_cfg_data;
                CFG_FAR_LOWER:    r_cfg.far_lower    <= i_cfg_data;
                CFG_MEDIUM_UPPER: r_cfg.medium_upper <= i_cfg_data;
                CFG_MEDIUM_LOWER: r_cfg.medium_lower <= i_cfg_data;
                CFG_CLOSE_UPPER:  r_cfg.close_upper  <= i_cfg_data;
                CFG_CLOSE_LOWER:  r_cfg.close_lower  <= i_cfg_data;
                CFG_DANGER_GAP:   r_cfg.danger_gap   <= i_cfg_data;
                CFG_WARN_GAP:     r_cfg.warn_gap     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/csmc_step.sv]
// One control tick: command decode, mode step, level clamp and output forming.
module csmc_step (
    input  csmc_pkg::t_cfg                 i_cfg,
    input  csmc_pkg::t_state               i_state,
    input  logic [7:0]                     i_cmd,
    input  logic [csmc_pkg::DIST_W-1:0]    i_dist,
    output csmc_pkg::t_state               o_state,
    output csmc_pkg::t_result              o_result
);
    import csmc_pkg::*;

    always_comb begin
        t_mode              m;
        logic [LEVEL_W:0]   lv;
        logic [TGT_W-1:0]   tg;
        t_band              pb;
        t_band              ab;
        t_light             ev;
        logic [CFG_W-1:0]   up;
        logic [CFG_W-1:0]   lo;
        logic               danger;
        logic [LEVEL_W-1:0] lvc;
        logic [LEVEL_W-1:0] x;
        logic [21:0]        prod;

        m  = i_state.mode;
        lv = {1'b0, i_state.level};
        tg = i_state.target;
        pb = i_state.pending_band;
        ab = i_state.active_band;
        ev = LIGHT_NONE;
        up = '0;
        lo = '0;
        danger = (i_dist <= {8'd0, i_cfg.danger_gap});

        case (i_cmd)
            CMD_ACCEL: begin
                if (m == MODE_OFF) begin
                    lv = lv + STEP_CMD;
                    ev = LIGHT_ACCEL;
                end
            end
            CMD_DECEL: begin
                if (m == MODE_ADAPTIVE) m = MODE_NORMAL;
                lv = lv - STEP_CMD;
                ev = LIGHT_DECEL;
            end
            CMD_STOP: begin
                m  = MODE_OFF;
                lv = {1'b0, LEVEL_MIN};
                ev = LIGHT_STOP;
            end
            CMD_OFF:      m = MODE_OFF;
            CMD_NORMAL: begin
                m  = MODE_NORMAL;
                tg = TGT_W'(lv);
            end
            CMD_ADAPTIVE: begin
                m  = MODE_ADAPTIVE;
                tg = TGT_W'(lv);
            end
            CMD_CLOSE:    pb = BAND_CLOSE;
            CMD_MEDIUM:   pb = BAND_MEDIUM;
            CMD_FAR:      pb = BAND_FAR;
            CMD_TGT_UP:   tg = tg + TGT_W'(STEP_CMD);
            CMD_TGT_DN:   tg = tg - TGT_W'(STEP_CMD);
            default: ;
        endcase

        case (m)
            MODE_ADAPTIVE: begin
                if (pb != BAND_NONE) ab = pb;
                pb = BAND_NONE;
                case (ab)
                    BAND_CLOSE: begin
                        up = i_cfg.close_upper;
                        lo = i_cfg.close_lower;
                    end
                    BAND_MEDIUM: begin
                        up = i_cfg.medium_upper;
                        lo = i_cfg.medium_lower;
                    end
                    BAND_FAR: begin
                        up = i_cfg.far_upper;
                        lo = i_cfg.far_lower;
                    end
                    default: ;
                endcase
                if (i_dist > {8'd0, up}) begin
                    lv = lv + STEP_ACC;
                end else if (i_dist < {8'd0, lo} && !danger) begin
                    lv = lv - STEP_ACC;
                end else if (danger) begin
                    lv = {1'b0, LEVEL_MIN};
                    m  = MODE_OFF;
                end
                if (tg > TGT_W'(LEVEL_MAX)) tg = TGT_W'(LEVEL_MAX);
                else if (tg < TGT_W'(LEVEL_MIN)) tg = TGT_W'(LEVEL_MIN);
                if (TGT_W'(lv) > tg) lv = tg[LEVEL_W:0];
            end
            MODE_NORMAL: begin
                if (tg > TGT_W'(LEVEL_MAX)) tg = TGT_W'(LEVEL_MAX);
                else if (tg < TGT_W'(LEVEL_MIN)) tg = TGT_W'(LEVEL_MIN);
                if (TGT_W'(lv) > tg) lv = tg[LEVEL_W:0];
                if (danger) begin
                    lv = {1'b0, LEVEL_MIN};
                    m  = MODE_OFF;
                end
            end
            default: begin
                if (danger) lv = {1'b0, LEVEL_MIN};
                else if (lv > {1'b0, LEVEL_MIN}) lv = lv - STEP_COAST;
            end
        endcase

        if (lv > {1'b0, LEVEL_MAX}) lvc = LEVEL_MAX;
        else if (lv < {1'b0, LEVEL_MIN}) lvc = LEVEL_MIN;
        else lvc = lv[LEVEL_W-1:0];

        x    = lvc - LEVEL_MIN;
        prod = 22'(x) * 22'(DISP_RECIP);

        o_state.mode         = m;
        o_state.level        = lvc;
        o_state.target       = tg;
        o_state.pending_band = pb;
        o_state.active_band  = ab;

        if (lvc < LEVEL_RUN) begin
            o_result.duty          = '0;
            o_result.speed_display = '0;
        end else begin
            o_result.duty          = lvc;
            o_result.speed_display = prod[21:16];
        end
        o_result.buzzer       = (m == MODE_NORMAL) && (i_dist < {8'd0, i_cfg.warn_gap})
                                && (lvc >= LEVEL_RUN);
        o_result.drive_mode   = m;
        o_result.target_level = tg;
        o_result.light_event  = ev;
    end

endmodule

[tb/sv/cruise_speed_mode_controller_top_tb.sv]
// Self-checking testbench for the cruise speed and mode controller with a tick-level scoreboard.
import csmc_pkg::*;

class cruise_tracker;
    localparam int SPEED_DIV = 20;

    t_cfg        regs;
    t_mode       mode;
    int unsigned level;
    logic [15:0] target;
    t_band       pending_band;
    t_band       active_band;
    t_result     due_results[$];
    int          errors;

    function new();
        regs         = '{8'd80, 8'd60, 8'd50, 8'd40, 8'd30, 8'd20, 8'd15, 8'd30};
        mode         = MODE_OFF;
        level        = 32'(LEVEL_MIN);
        target       = 16'(LEVEL_MIN);
        pending_band = BAND_NONE;
        active_band  = BAND_NONE;
        errors       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        case (idx)
            CFG_FAR_UPPER:    regs.far_upper    = value;
            CFG_FAR_LOWER:    regs.far_lower    = value;
            CFG_MEDIUM_UPPER: regs.medium_upper = value;
            CFG_MEDIUM_LOWER: regs.medium_lower = value;
            CFG_CLOSE_UPPER:  regs.close_upper  = value;
            CFG_CLOSE_LOWER:  regs.close_lower  = value;
            CFG_DANGER_GAP:   regs.danger_gap   = value;
            CFG_WARN_GAP:     regs.warn_gap     = value;
            default: ;
        endcase
    endfunction

    function void clamp_target();
        if (target > LEVEL_MAX) begin
            target = 16'(LEVEL_MAX);
        end else if (target < LEVEL_MIN) begin
            target = 16'(LEVEL_MIN);
        end
    endfunction

    function void note_tick(logic [7:0] cmd, logic [15:0] gap);
        t_light      light;
        int unsigned upper;
        int unsigned lower;
        int unsigned duty;
        t_result     want;
        light = LIGHT_NONE;
        upper = 0;
        lower = 0;
        case (cmd)
            CMD_ACCEL: begin
                if (mode == MODE_OFF) begin
                    level = level + STEP_CMD;
                    light = LIGHT_ACCEL;
                end
            end
            CMD_DECEL: begin
                if (mode == MODE_ADAPTIVE) begin
                    mode = MODE_NORMAL;
                end
                level = level - STEP_CMD;
                light = LIGHT_DECEL;
            end
            CMD_STOP: begin
                mode  = MODE_OFF;
                level = 32'(LEVEL_MIN);
                light = LIGHT_STOP;
            end
            CMD_OFF:      mode = MODE_OFF;
            CMD_NORMAL: begin
                mode   = MODE_NORMAL;
                target = 16'(level);
            end
            CMD_ADAPTIVE: begin
                mode   = MODE_ADAPTIVE;
                target = 16'(level);
            end
            CMD_CLOSE:    pending_band = BAND_CLOSE;
            CMD_MEDIUM:   pending_band = BAND_MEDIUM;
            CMD_FAR:      pending_band = BAND_FAR;
            CMD_TGT_UP:   target = target + STEP_CMD;
            CMD_TGT_DN:   target = target - STEP_CMD;
            default: ;
        endcase

        if (mode == MODE_ADAPTIVE) begin
            if (pending_band != BAND_NONE) begin
                active_band = pending_band;
            end
            pending_band = BAND_NONE;
            case (active_band)
                BAND_CLOSE: begin
                    upper = 32'(regs.close_upper);
                    lower = 32'(regs.close_lower);
                end
                BAND_MEDIUM: begin
                    upper = 32'(regs.medium_upper);
                    lower = 32'(regs.medium_lower);
                end
                BAND_FAR: begin
                    upper = 32'(regs.far_upper);
                    lower = 32'(regs.far_lower);
                end
                default: ;
            endcase
            if (gap > upper) begin
                level = level + STEP_ACC;
            end else if (gap < lower && gap > regs.danger_gap) begin
                level = level - STEP_ACC;
            end else if (gap <= regs.danger_gap) begin
                level = 32'(LEVEL_MIN);
                mode  = MODE_OFF;
            end
            clamp_target();
            if (level > target) level = 32'(target);
        end else if (mode == MODE_NORMAL) begin
            clamp_target();
            if (level > target) level = 32'(target);
            if (gap <= regs.danger_gap) begin
                level = 32'(LEVEL_MIN);
                mode  = MODE_OFF;
            end
        end else begin
            if (gap <= regs.danger_gap) begin
                level = 32'(LEVEL_MIN);
            end else if (level > LEVEL_MIN) begin
                level = level - STEP_COAST;
            end
        end

        if (level > LEVEL_MAX) begin
            level = 32'(LEVEL_MAX);
        end else if (level < LEVEL_MIN) begin
            level = 32'(LEVEL_MIN);
        end

        duty = (level < LEVEL_RUN) ? 0 : level;
        want.duty          = LEVEL_W'(duty);
        want.speed_display = (duty == 0) ? 6'd0 : 6'((duty - LEVEL_MIN) / SPEED_DIV);
        want.buzzer        = (mode == MODE_NORMAL) && (gap < regs.warn_gap) &&
                             (level >= LEVEL_RUN);
        want.drive_mode    = mode;
        want.target_level  = target;
        want.light_event   = light;
        due_results.push_back(want);
    endfunction

    task report(string msg);
        if (errors < 40) $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    task cmp_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_tick(t_result got);
        t_result want;
        if (due_results.size() == 0) begin
            report("result word with no tick outstanding");
        end else begin
            want = due_results.pop_front();
            cmp_field("duty", 16'(got.duty), 16'(want.duty));
            cmp_field("speed_display", 16'(got.speed_display), 16'(want.speed_display));
            cmp_field("buzzer", 16'(got.buzzer), 16'(want.buzzer));
            cmp_field("drive_mode", 16'(got.drive_mode), 16'(want.drive_mode));
            cmp_field("target_level", got.target_level, want.target_level);
            cmp_field("light_event", 16'(got.light_event), 16'(want.light_event));
        end
    endtask

    function int pending();
        return due_results.size();
    endfunction
endclass

module cruise_speed_mode_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_cmd_byte;
    logic [DIST_W-1:0]    i_distance;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [LEVEL_W-1:0]   o_duty;
    logic [5:0]           o_speed_display;
    logic                 o_buzzer;
    logic [1:0]           o_drive_mode;
    logic [TGT_W-1:0]     o_target_level;
    logic [1:0]           o_light_event;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    cruise_tracker board;
    t_cfg          start_cfg;
    t_cfg          cfg;
    bit            hold_req = 1'b0;
    bit            calm = 1'b0;

    logic [7:0] cmd_set [11] = '{CMD_ACCEL, CMD_DECEL, CMD_STOP, CMD_OFF, CMD_NORMAL,
                                 CMD_ADAPTIVE, CMD_CLOSE, CMD_MEDIUM, CMD_FAR,
                                 CMD_TGT_UP, CMD_TGT_DN};

    logic [23:0] opening [27] = '{
        {CMD_ACCEL, 16'hFFFF}, {CMD_ACCEL, 16'd100}, {CMD_ACCEL, 16'd100},
        {CMD_OFF, 16'd100}, {CMD_NORMAL, 16'd25}, {CMD_ACCEL, 16'd200},
        {CMD_TGT_UP, 16'd200}, {CMD_TGT_DN, 16'd15}, {CMD_ACCEL, 16'd100},
        {CMD_ADAPTIVE, 16'd10}, {CMD_ACCEL, 16'd100}, {CMD_CLOSE, 16'd25},
        {CMD_MEDIUM, 16'd45}, {CMD_FAR, 16'd70}, {8'h00, 16'd90},
        {8'hFF, 16'd50}, {CMD_DECEL, 16'd100}, {CMD_ADAPTIVE, 16'd0},
        {CMD_TGT_DN, 16'd100}, {CMD_TGT_DN, 16'd100}, {CMD_TGT_DN, 16'd100},
        {CMD_TGT_DN, 16'd100}, {CMD_TGT_UP, 16'd100}, {CMD_STOP, 16'd100},
        {CMD_DECEL, 16'd100}, {CMD_NORMAL, 16'hFFFF}, {CMD_OFF, 16'd16}
    };

    cruise_speed_mode_controller_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd_byte      (i_cmd_byte),
        .i_distance      (i_distance),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_duty          (o_duty),
        .o_speed_display (o_speed_display),
        .o_buzzer        (o_buzzer),
        .o_drive_mode    (o_drive_mode),
        .o_target_level  (o_target_level),
        .o_light_event   (o_light_event),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [7:0] pick_cmd();
        int r;
        r = $urandom_range(0, 13);
        if (r < 11) return cmd_set[r];
        if (r == 11) return CMD_ACCEL;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_dist();
        case ($urandom_range(0, 7))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($urandom_range(0, 20));
            6:       return 16'($urandom_range(200, 300));
            7: begin
                case ($urandom_range(0, 3))
                    0:       return 16'd0;
                    1:       return 16'hFFFF;
                    2:       return 16'd255;
                    default: return 16'd256;
                endcase
            end
            default: return 16'($urandom_range(0, 100));
        endcase
    endfunction

    function automatic t_cfg ordered_cfg();
        t_cfg c;
        c.danger_gap   = 8'($urandom_range(0, 30));
        c.close_lower  = c.danger_gap + 8'($urandom_range(0, 15));
        c.close_upper  = c.close_lower + 8'($urandom_range(0, 15));
        c.medium_lower = c.close_upper + 8'($urandom_range(0, 15));
        c.medium_upper = c.medium_lower + 8'($urandom_range(0, 15));
        c.far_lower    = c.medium_upper + 8'($urandom_range(0, 15));
        c.far_upper    = c.far_lower + 8'($urandom_range(0, 15));
        c.warn_gap     = 8'($urandom_range(0, 120));
        return c;
    endfunction

    task automatic send_word(logic [7:0] cmd, logic [15:0] gap);
        i_in_valid <= 1'b1;
        i_cmd_byte <= cmd;
        i_distance <= gap;
        do @(posedge i_clk); while (o_in_stall);
        board.note_tick(cmd, gap);
    endtask

    task automatic idle_in(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic offer(logic [7:0] cmd, logic [15:0] gap, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) idle_in($urandom_range(1, 10));
        send_word(cmd, gap);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        board.set_reg(idx, value);
    endtask

    task automatic load_regs(t_cfg c);
        write_reg(CFG_FAR_UPPER, c.far_upper);
        write_reg(CFG_FAR_LOWER, c.far_lower);
        write_reg(CFG_MEDIUM_UPPER, c.medium_upper);
        write_reg(CFG_MEDIUM_LOWER, c.medium_lower);
        write_reg(CFG_CLOSE_UPPER, c.close_upper);
        write_reg(CFG_CLOSE_LOWER, c.close_lower);
        write_reg(CFG_DANGER_GAP, c.danger_gap);
        write_reg(CFG_WARN_GAP, c.warn_gap);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count, bit idling);
        int  sent;
        int  len;
        int  kind;
        bit  gaps;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 9);
            gaps = idling && ($urandom_range(0, 2) != 0);
            if (kind < 2) begin
                len = $urandom_range(4, 24);
                offer(CMD_OFF, pick_dist(), gaps);
                repeat (len) offer(CMD_ACCEL, 16'($urandom_range(256, 65535)), gaps);
                offer(($urandom_range(0, 1) != 0) ? CMD_NORMAL : CMD_ADAPTIVE,
                      pick_dist(), gaps);
                sent += len + 2;
            end else if (kind < 8) begin
                len = $urandom_range(5, 15);
                repeat (len) offer(pick_cmd(), pick_dist(), gaps);
                sent += len;
            end else begin
                len = $urandom_range(1, 5);
                repeat (len) offer(8'($urandom_range(0, 255)),
                                   16'($urandom_range(0, 65535)), gaps);
                sent += len;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_tick({o_duty, o_speed_display, o_buzzer, o_drive_mode,
                              o_target_level, o_light_event});
        end
    end

    initial begin : out_side
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 7))
                    0, 1: begin
                        i_out_stall <= 1'b1;
                        repeat ($urandom_range(1, 10)) @(posedge i_clk);
                    end
                    2: begin
                        i_out_stall <= 1'b0;
                        repeat (40) @(posedge i_clk);
                    end
                    default: begin
                        i_out_stall <= 1'b0;
                        @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_cmd_byte <= 8'h00;
        i_distance <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        board      = new();
        start_cfg  = board.regs;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[k]) send_word(opening[k][23:16], opening[k][15:0]);
        drain();

        for (int ph = 1; ph <= 6; ph++) begin
            case (ph)
                1:       cfg = '0;
                2:       cfg = '1;
                3, 5:    cfg = {$urandom, $urandom};
                4:       cfg = ordered_cfg();
                default: cfg = start_cfg;
            endcase
            load_regs(cfg);
            if (ph == 2) hold_req = 1'b1;
            calm = (ph == 6);
            run_random(290, !calm);
            drain();
        end

        if (board.errors == 0 && board.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
